@@ design/lcb64_pkg.sv @@
package lcb64_pkg;

    // Group queue between the byte collector and the character serializer.
    localparam int FifoDepth = 2;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    localparam logic [7:0] PadChar = 8'h6E;  // 'n'

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // One closed group: three bytes, number of pad characters, end-of-message mark.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pads;
        logic        last;
    } group_t;

    // Base64 alphabet folded to lower case.
    function automatic logic [7:0] map_char(input logic [5:0] v);
        logic [7:0] c;
        if (v inside {[6'd0:6'd25]}) begin
            c = 8'h61 + {2'b00, v};
        end else if (v inside {[6'd26:6'd51]}) begin
            c = 8'h61 + ({2'b00, v} - 8'd26);
        end else if (v inside {[6'd52:6'd61]}) begin
            c = 8'h30 + ({2'b00, v} - 8'd52);
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ design/lcb64_front.sv @@
module lcb64_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcb64_pkg::in_item_t s_data,
    input  logic                q_full,
    output logic                q_push,
    output lcb64_pkg::group_t   q_group
);

    logic [15:0] held_bytes_reg, held_bytes_next;
    logic [1:0]  held_count_reg, held_count_next;
    logic        closes;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign closes  = s_data.last_byte || (held_count_reg == 2'd2);
    assign q_push  = accept && closes;

    always_comb begin
        q_group.last = s_data.last_byte;
        case (held_count_reg)
            2'd0: begin
                q_group.word = {s_data.data_byte, 16'h0000};
                q_group.pads = 2'd2;
            end
            2'd1: begin
                q_group.word = {held_bytes_reg[15:8], s_data.data_byte, 8'h00};
                q_group.pads = 2'd1;
            end
            default: begin
                q_group.word = {held_bytes_reg, s_data.data_byte};
                q_group.pads = 2'd0;
            end
        endcase
    end

    always_comb begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        if (accept) begin
            if (closes) begin
                held_bytes_next = 16'h0000;
                held_count_next = 2'd0;
            end else if (held_count_reg == 2'd0) begin
                held_bytes_next = {s_data.data_byte, 8'h00};
                held_count_next = 2'd1;
            end else begin
                held_bytes_next = {held_bytes_reg[15:8], s_data.data_byte};
                held_count_next = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg <= 16'h0000;
            held_count_reg <= 2'd0;
        end else begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

@@ design/lcb64_fifo.sv @@
module lcb64_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lcb64_pkg::group_t push_group,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output lcb64_pkg::group_t head_group
);

    lcb64_pkg::group_t entry_reg [lcb64_pkg::FifoDepth];

    logic [lcb64_pkg::FifoPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lcb64_pkg::FifoPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lcb64_pkg::FifoCntW-1:0] count_reg, count_next;
    logic                           do_push, do_pop;

    localparam logic [lcb64_pkg::FifoPtrW-1:0] LastPtr =
        lcb64_pkg::FifoPtrW'(lcb64_pkg::FifoDepth - 1);
    localparam logic [lcb64_pkg::FifoCntW-1:0] FullCnt =
        lcb64_pkg::FifoCntW'(lcb64_pkg::FifoDepth);

    assign full       = (count_reg == FullCnt);
    assign head_valid = (count_reg != '0);
    assign head_group = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

@@ design/lcb64_back.sv @@
module lcb64_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  lcb64_pkg::group_t    head_group,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcb64_pkg::out_item_t m_data
);

    logic [1:0]           char_idx_reg, char_idx_next;
    logic                 m_valid_reg, m_valid_next;
    lcb64_pkg::out_item_t m_data_reg, m_data_next;
    logic [5:0]           sextet;
    logic                 is_pad;
    logic                 load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The output register takes a new character whenever a group is queued and the register is empty or being drained.
    assign load = head_valid && (!m_valid_reg || m_ready);
    assign pop  = load && (char_idx_reg == 2'd3);

    always_comb begin
        case (char_idx_reg)
            2'd0:    sextet = head_group.word[23:18];
            2'd1:    sextet = head_group.word[17:12];
            2'd2:    sextet = head_group.word[11:6];
            default: sextet = head_group.word[5:0];
        endcase
    end

    // Pads occupy the trailing positions of the group.
    assign is_pad = ({1'b0, char_idx_reg} + {1'b0, head_group.pads}) >= 3'd4;

    always_comb begin
        char_idx_next = char_idx_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        if (load) begin
            char_idx_next         = char_idx_reg + 2'd1;
            m_valid_next          = 1'b1;
            m_data_next.out_char  = is_pad ? lcb64_pkg::PadChar : lcb64_pkg::map_char(sextet);
            m_data_next.last_char = head_group.last && (char_idx_reg == 2'd3);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_idx_reg <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            char_idx_reg <= char_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule

@@ design/lowercase_base64_encoder.sv @@
// Path: the byte that closes a group is written into the group queue; the first character
// of that group is then registered in the output register, and the other three follow it.
// Throughput: one byte per cycle in while the queue has room, one character per cycle out
// while m_ready is high and a group is queued; the serializer's output sets the sustained rate.
// Reset: synchronous, active low; clears the held bytes, the group queue and the output.
module lowercase_base64_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lcb64_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lcb64_pkg::out_item_t m_data
);

    lcb64_pkg::group_t push_group;
    lcb64_pkg::group_t head_group;
    logic              push;
    logic              full;
    logic              pop;
    logic              head_valid;

    lcb64_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (full),
        .q_push  (push),
        .q_group (push_group)
    );

    lcb64_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    lcb64_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

@@ design/lcb64_checker.sv @@
module lcb64_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input lcb64_pkg::out_item_t m_data
);

    // Position of the next output transfer within its group of four.
    logic [1:0] out_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_pos_reg <= 2'd0;
        end else if (m_valid && m_ready) begin
            out_pos_reg <= out_pos_reg + 2'd1;
        end
    end

    a_hold_valid : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped without a transfer");

    a_hold_data : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    a_alphabet : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.out_char >= 8'h61 && m_data.out_char <= 8'h7A) ||
                     (m_data.out_char >= 8'h30 && m_data.out_char <= 8'h39) ||
                     m_data.out_char == 8'h2B || m_data.out_char == 8'h2F))
        else $error("character outside the folded alphabet");

    a_last_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_char |-> out_pos_reg == 2'd3)
        else $error("last mark not on the fourth character of a group");

endmodule

bind lowercase_base64_encoder lcb64_checker u_checker (.*);
